// ----- hdl/ezr_pkg.sv -----
package ezr_pkg;

  localparam int TRIG_STEPS = 16;
  localparam int STEP_W = $clog2(TRIG_STEPS);
  localparam int CW = 34;
  localparam int ZW = 33;
  localparam int DW = 38;
  localparam int FRAC = 30;
  localparam int MSTEPS = 24;
  localparam int MSTEP_W = $clog2(MSTEPS);

  localparam logic signed [16:0] HALF_TURN = 17'sd23040;
  localparam logic signed [16:0] FULL_TURN = 17'sd46080;
  localparam logic signed [16:0] QUARTER_TURN = 17'sd11520;
  localparam logic signed [18:0] RAD_SCALE = 19'sd146409;
  localparam logic signed [CW-1:0] GAIN_INV = CW'(652032874);
  localparam logic signed [DW-1:0] Q_ONE = DW'(64'sd1 <<< FRAC);

  typedef enum logic {
    REQ_POS = 1'b0,
    REQ_ATT = 1'b1
  } req_t;

  typedef enum logic [4:0] {
    R_SX, R_CX, R_SY, R_CY, R_SZ, R_CZ, R_CZSY, R_SZSY,
    R_E00, R_E01, R_E02, R_E10, R_E11, R_E12, R_E20, R_E21, R_E22,
    R_PX, R_PY, R_PZ, R_VX, R_VY, R_VZ, R_ONE
  } reg_sel_t;

  typedef enum logic [1:0] {
    OP_LOAD, OP_ADD, OP_SUB, OP_NEG
  } mop_t;

  typedef struct packed {
    reg_sel_t src_a;
    reg_sel_t src_b;
    reg_sel_t dst;
    mop_t     op;
  } uop_t;

  typedef struct packed {
    logic signed [ZW-1:0] z;
    logic                 neg;
  } red_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [STEP_W-1:0] i);
    logic [31:0] v;
    case (5'(i))
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return signed'({1'b0, v});
  endfunction

  function automatic red_t reduce_angle(input logic signed [15:0] ang);
    logic signed [16:0] a;
    logic signed [35:0] p;
    red_t r;
    a = {ang[15], ang};
    r.neg = 1'b0;
    if (a >= HALF_TURN) a = a - FULL_TURN;
    if (a < -HALF_TURN) a = a + FULL_TURN;
    if (a > QUARTER_TURN) begin
      a = a - HALF_TURN;
      r.neg = 1'b1;
    end else if (a < -QUARTER_TURN) begin
      a = a + HALF_TURN;
      r.neg = 1'b1;
    end
    p = a * RAD_SCALE;
    r.z = p[ZW-1:0];
    return r;
  endfunction

  function automatic uop_t uop(input logic [MSTEP_W-1:0] s);
    uop_t u;
    case (s)
      5'd0:  u = '{R_CZ,   R_SY,  R_CZSY, OP_LOAD};
      5'd1:  u = '{R_SZ,   R_SY,  R_SZSY, OP_LOAD};
      5'd2:  u = '{R_CZ,   R_CY,  R_E00,  OP_LOAD};
      5'd3:  u = '{R_CZSY, R_SX,  R_E01,  OP_LOAD};
      5'd4:  u = '{R_SZ,   R_CX,  R_E01,  OP_SUB};
      5'd5:  u = '{R_CZSY, R_CX,  R_E02,  OP_LOAD};
      5'd6:  u = '{R_SZ,   R_SX,  R_E02,  OP_ADD};
      5'd7:  u = '{R_SZ,   R_CY,  R_E10,  OP_LOAD};
      5'd8:  u = '{R_SZSY, R_SX,  R_E11,  OP_LOAD};
      5'd9:  u = '{R_CZ,   R_CX,  R_E11,  OP_ADD};
      5'd10: u = '{R_SZSY, R_CX,  R_E12,  OP_LOAD};
      5'd11: u = '{R_CZ,   R_SX,  R_E12,  OP_SUB};
      5'd12: u = '{R_SY,   R_ONE, R_E20,  OP_NEG};
      5'd13: u = '{R_CY,   R_SX,  R_E21,  OP_LOAD};
      5'd14: u = '{R_CY,   R_CX,  R_E22,  OP_LOAD};
      5'd15: u = '{R_E00,  R_PX,  R_VX,   OP_LOAD};
      5'd16: u = '{R_E01,  R_PY,  R_VX,   OP_ADD};
      5'd17: u = '{R_E02,  R_PZ,  R_VX,   OP_ADD};
      5'd18: u = '{R_E10,  R_PX,  R_VY,   OP_LOAD};
      5'd19: u = '{R_E11,  R_PY,  R_VY,   OP_ADD};
      5'd20: u = '{R_E12,  R_PZ,  R_VY,   OP_ADD};
      5'd21: u = '{R_E20,  R_PX,  R_VZ,   OP_LOAD};
      5'd22: u = '{R_E21,  R_PY,  R_VZ,   OP_ADD};
      5'd23: u = '{R_E22,  R_PZ,  R_VZ,   OP_ADD};
      default: u = '{R_ONE, R_ONE, R_VZ, OP_ADD};
    endcase
    return u;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [DW-1:0] v);
    logic signed [31:0] r;
    if (v > DW'(64'sd2147483647)) r = 32'sh7FFFFFFF;
    else if (v < DW'(-64'sd2147483648)) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ----- hdl/ezr_cordic.sv -----
module ezr_cordic (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [15:0]            angle,
  output logic                          done,
  output logic signed [ezr_pkg::CW-1:0] sin_q,
  output logic signed [ezr_pkg::CW-1:0] cos_q
);
  import ezr_pkg::*;

  logic signed [CW-1:0] x, y, x_next, y_next, dx, dy;
  logic signed [ZW-1:0] z, z_next, at;
  logic                 neg, busy;
  logic [STEP_W-1:0]    step;
  red_t                 red;

  always_comb begin
    red = reduce_angle(angle);
    dx = y >>> step;
    dy = x >>> step;
    at = atan_q30(step);
    if (!z[ZW-1]) begin
      x_next = x - dx;
      y_next = y + dy;
      z_next = z - at;
    end else begin
      x_next = x + dx;
      y_next = y - dy;
      z_next = z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        x <= GAIN_INV;
        y <= '0;
        z <= red.z;
        neg <= red.neg;
      end else if (busy) begin
        x <= x_next;
        y <= y_next;
        z <= z_next;
        if (step == STEP_W'(TRIG_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          sin_q <= neg ? -y_next : y_next;
          cos_q <= neg ? -x_next : x_next;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

endmodule

// ----- hdl/euler_zyx_vector_rotation_unit.sv -----
// euler zyx vector rotation unit
// input channel: in_valid / in_stall with req_type, pos_x/y/z and roll/pitch/yaw_deg.
// a position item (req_type 0) replaces the stored position and gives no
// result. an attitude item (req_type 1) gives one result item on the output channel
// (out_valid / out_stall, rot_out_x/y/z): the stored position rotated by
// Rz(yaw) * Ry(pitch) * Rx(roll), saturated Q15.16.
// for an attitude item, one shared cordic runs TRIG_STEPS iterations per angle,
// then one shared multiplier runs 24 multiply-accumulate steps for the matrix and
// the vector product, and then out_valid rises. the block handles one item at a
// time: in_stall is high from acceptance of an attitude item until its result is
// taken. while out_stall is high the result holds and no new item is taken.
// reset (rst, synchronous) clears the stored position to zero and empties the block.
module euler_zyx_vector_rotation_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               req_type,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [15:0] roll_deg,
  input  logic signed [15:0] pitch_deg,
  input  logic signed [15:0] yaw_deg,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] rot_out_x,
  output logic signed [31:0] rot_out_y,
  output logic signed [31:0] rot_out_z
);
  import ezr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_TRIG = 4'b0010,
    S_MAT  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state;
  logic trig_start, trig_done;
  logic [1:0] ang_idx;
  logic [MSTEP_W-1:0] mstep;
  logic signed [15:0] roll, pitch, yaw, ang;
  logic signed [CW-1:0] sin_q, cos_q;
  logic signed [31:0] px, py, pz;
  logic signed [DW-1:0] sx, cx, sy, cy, sz, cz, czsy, szsy;
  logic signed [DW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [DW-1:0] vx, vy, vz;
  logic signed [DW-1:0] opa, opb, cur, res, sh;
  logic signed [CW-1:0] ma, mb;
  logic signed [2*CW-1:0] prod;
  uop_t u;

  function automatic logic signed [DW-1:0] rd(input reg_sel_t s,
      input logic signed [DW-1:0] a0, a1, a2, a3, a4, a5, a6, a7,
      input logic signed [DW-1:0] b0, b1, b2, b3, b4, b5, b6, b7, b8,
      input logic signed [DW-1:0] c0, c1, c2, c3, c4, c5);
    logic signed [DW-1:0] r;
    unique case (s)
      R_SX:   r = a0;
      R_CX:   r = a1;
      R_SY:   r = a2;
      R_CY:   r = a3;
      R_SZ:   r = a4;
      R_CZ:   r = a5;
      R_CZSY: r = a6;
      R_SZSY: r = a7;
      R_E00:  r = b0;
      R_E01:  r = b1;
      R_E02:  r = b2;
      R_E10:  r = b3;
      R_E11:  r = b4;
      R_E12:  r = b5;
      R_E20:  r = b6;
      R_E21:  r = b7;
      R_E22:  r = b8;
      R_PX:   r = c0;
      R_PY:   r = c1;
      R_PZ:   r = c2;
      R_VX:   r = c3;
      R_VY:   r = c4;
      R_VZ:   r = c5;
      R_ONE:  r = Q_ONE;
      default: r = '0;
    endcase
    return r;
  endfunction

  always_comb begin
    case (ang_idx)
      2'd0:    ang = roll;
      2'd1:    ang = pitch;
      default: ang = yaw;
    endcase
  end

  ezr_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (trig_start),
    .angle (ang),
    .done  (trig_done),
    .sin_q (sin_q),
    .cos_q (cos_q)
  );

  always_comb begin
    u = uop(mstep);
    opa = rd(u.src_a, sx, cx, sy, cy, sz, cz, czsy, szsy,
             e00, e01, e02, e10, e11, e12, e20, e21, e22,
             DW'(px), DW'(py), DW'(pz), vx, vy, vz);
    opb = rd(u.src_b, sx, cx, sy, cy, sz, cz, czsy, szsy,
             e00, e01, e02, e10, e11, e12, e20, e21, e22,
             DW'(px), DW'(py), DW'(pz), vx, vy, vz);
    cur = rd(u.dst, sx, cx, sy, cy, sz, cz, czsy, szsy,
             e00, e01, e02, e10, e11, e12, e20, e21, e22,
             DW'(px), DW'(py), DW'(pz), vx, vy, vz);
    // multiplier operands never exceed the cordic width
    ma = CW'(opa);
    mb = CW'(opb);
    prod = ma * mb;
    sh = DW'(prod >>> FRAC);
    unique case (u.op)
      OP_LOAD: res = sh;
      OP_ADD:  res = cur + sh;
      OP_SUB:  res = cur - sh;
      OP_NEG:  res = -sh;
      default: res = sh;
    endcase
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign rot_out_x = sat32(vx);
  assign rot_out_y = sat32(vy);
  assign rot_out_z = sat32(vz);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      trig_start <= 1'b0;
      ang_idx <= '0;
      mstep <= '0;
      px <= '0;
      py <= '0;
      pz <= '0;
    end else begin
      trig_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (req_type == REQ_POS) begin
              px <= pos_x;
              py <= pos_y;
              pz <= pos_z;
            end else begin
              roll <= roll_deg;
              pitch <= pitch_deg;
              yaw <= yaw_deg;
              ang_idx <= '0;
              trig_start <= 1'b1;
              state <= S_TRIG;
            end
          end
        end
        S_TRIG: begin
          if (trig_done) begin
            case (ang_idx)
              2'd0: begin
                sx <= DW'(sin_q);
                cx <= DW'(cos_q);
              end
              2'd1: begin
                sy <= DW'(sin_q);
                cy <= DW'(cos_q);
              end
              default: begin
                sz <= DW'(sin_q);
                cz <= DW'(cos_q);
              end
            endcase
            if (ang_idx == 2'd2) begin
              mstep <= '0;
              state <= S_MAT;
            end else begin
              ang_idx <= ang_idx + 1'b1;
              trig_start <= 1'b1;
            end
          end
        end
        S_MAT: begin
          case (u.dst)
            R_CZSY:  czsy <= res;
            R_SZSY:  szsy <= res;
            R_E00:   e00 <= res;
            R_E01:   e01 <= res;
            R_E02:   e02 <= res;
            R_E10:   e10 <= res;
            R_E11:   e11 <= res;
            R_E12:   e12 <= res;
            R_E20:   e20 <= res;
            R_E21:   e21 <= res;
            R_E22:   e22 <= res;
            R_VX:    vx <= res;
            R_VY:    vy <= res;
            default: vz <= res;
          endcase
          if (mstep == MSTEP_W'(MSTEPS - 1)) begin
            state <= S_OUT;
          end else begin
            mstep <= mstep + 1'b1;
          end
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_onehot_state: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_done_in_trig: assert property (@(posedge clk) disable iff (rst)
    trig_done |-> state == S_TRIG)
    else $error("cordic finished outside trig phase");
  a_out_after_mat: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_MAT && $past(mstep) == MSTEP_W'(MSTEPS - 1))
    else $error("result without full matrix sequence");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rot_out_x) && $stable(rot_out_z))
    else $error("stalled result changed");

endmodule
